FILE: src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 8;
  localparam int CAP_W       = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int CAP_RESET   = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

FILE: src/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [VALUE_W-1:0]  new_value,
  input  logic [PRIO_W-1:0]   new_prio,
  input  entry_t              left_entry,
  input  logic                left_keep,
  input  entry_t              right_entry,
  output logic                keep,
  output entry_t              entry
);

  entry_t entry_next;

  // cell holds its entry on push when it outranks or ties the new one
  assign keep = entry.valid && (entry.prio >= new_prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next.valid = 1'b1;
          entry_next.value = new_value;
          entry_next.prio  = new_prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry.value <= entry_next.value;
    entry.prio  <= entry_next.prio;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind; tdata value, priority_req
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata popped_value, count, flags; tuser
// cfg       in         cfg_we (no handshake)          cfg_wdata capacity
//
// One item per cycle while the output is not stalled: every cell compares against
// the broadcast entry and shifts in the same cycle; the result sits in one output register.
// The result is valid in the cycle after the input is accepted.
// Reset clears cell valid bits, the count, capacity (to 16) and the output valid.
// Input is taken whenever the output register is empty or being drained.

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] value, [39:32] priority_req
  input  logic                  s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] popped_value, [36:32] entry_count,
                                                // [37] is_empty, [38] is_full, [39] zero
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] pop_valid, [1] refused
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  eff_cap;
  logic [CMPW-1:0]  count_ext;
  logic [CMPW-1:0]  count_next_ext;

  logic               accept;
  logic               in_kind;
  logic [VALUE_W-1:0] in_value;
  logic [PRIO_W-1:0]  in_prio;
  logic               push_ok;
  logic               pop_ok;
  logic               refuse;
  cell_ctrl_t         ctrl;

  entry_t cells [DEPTH];
  logic   keeps [DEPTH];

  assign in_kind  = s_axis_tuser;
  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_prio  = s_axis_tdata[VALUE_W +: PRIO_W];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cap_ext   = CMPW'(capacity);
  assign count_ext = CMPW'(count);

  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(DEPTH)) begin
      eff_cap = CMPW'(DEPTH);
    end
  end

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    refuse  = 1'b0;
    if (accept) begin
      if (in_kind == KIND_PUSH) begin
        push_ok = count_ext < eff_cap;
        refuse  = !push_ok;
      end else begin
        pop_ok = count != '0;
        refuse = !pop_ok;
      end
    end
  end

  assign ctrl.push = push_ok;
  assign ctrl.pop  = pop_ok;

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok) begin
      count_next = count - CW'(1);
    end
  end

  assign count_next_ext = CMPW'(count_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_k;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = cells[i-1];
      assign left_k = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (in_value),
      .new_prio    (in_prio),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .keep        (keeps[i]),
      .entry       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_W'(CAP_RESET);
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      count <= count_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata[VALUE_W-1:0]                  <= pop_ok ? cells[0].value : '0;
      m_axis_tdata[VALUE_W +: COUNT_OUT_W]       <= count_next_ext[COUNT_OUT_W-1:0];
      m_axis_tdata[VALUE_W + COUNT_OUT_W]        <= count_next == '0;
      m_axis_tdata[VALUE_W + COUNT_OUT_W + 1]    <= count_next_ext >= eff_cap;
      m_axis_tdata[OUT_DATA_W-1]                 <= 1'b0;
      m_axis_tuser[0]                            <= pop_ok;
      m_axis_tuser[1]                            <= refuse;
    end
  end

endmodule

FILE: tb/sv/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 200000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 183;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } queue_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     popped;
    logic                   pop_valid;
    logic                   refused;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
    logic                   full;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = KIND_PUSH;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // shadow of the sorted store
  logic [VALUE_W-1:0] shadow_val [DEPTH];
  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  int shadow_count = 0;
  logic [CAP_W-1:0] cap_setting = CAP_W'(CAP_RESET);

  queue_op_t op_q[$];
  queue_op_t cur_op;
  queue_status_t status_q[$];
  queue_status_t want;
  int accepted = 0;
  int checked = 0;
  int errors = 0;
  int cycles = 0;

  int phase_cap [PHASES] = '{31, 16, 1, 5, 8, 17, 3, 16, 4, 30};
  int phase_push_pct [PHASES] = '{80, 50, 50, 60, 40, 55, 50, 90, 40, 30};

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int usable_slots();
    int c;
    c = int'(cap_setting);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic queue_status_t apply_queue_op(queue_op_t op);
    queue_status_t r;
    int pos;
    int cap;
    r = '0;
    cap = usable_slots();
    if (op.kind == KIND_PUSH) begin
      if (shadow_count >= cap) begin
        r.refused = 1'b1;
      end else begin
        pos = 0;
        // equal priorities keep arrival order
        while (pos < shadow_count && shadow_prio[pos] >= op.prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_val[pos] = op.value;
        shadow_prio[pos] = op.prio;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.refused = 1'b1;
      end else begin
        r.popped = shadow_val[0];
        r.pop_valid = 1'b1;
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_val[i] = shadow_val[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end
    r.count = COUNT_OUT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    r.full = (shadow_count >= cap);
    return r;
  endfunction

  function automatic logic no_idle_window(int n);
    return n >= 700 && n < 1000;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want_v);
    if (errors < 40)
      $display("ERROR result %0d %s: got %0h expected %0h", checked, field, got, want_v);
    errors++;
  endtask

  task automatic add_op(logic kind, logic [VALUE_W-1:0] value, logic [PRIO_W-1:0] prio);
    queue_op_t o;
    o.kind = kind;
    o.value = value;
    o.prio = prio;
    op_q.push_back(o);
  endtask

  task automatic wait_idle();
    while (op_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = v;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(apply_queue_op(cur_op));
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_q.size() != 0 && (no_idle_window(accepted) || $urandom_range(99) >= 8)) begin
          cur_op = op_q.pop_front();
          s_axis_tuser <= cur_op.kind;
          s_axis_tdata <= {cur_op.prio, cur_op.value};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
        end else begin
          want = status_q.pop_front();
          if (m_axis_tdata[31:0] !== want.popped)
            report_mismatch("popped_value", m_axis_tdata[31:0], want.popped);
          if (m_axis_tuser[0] !== want.pop_valid)
            report_mismatch("pop_valid", 32'(m_axis_tuser[0]), 32'(want.pop_valid));
          if (m_axis_tuser[1] !== want.refused)
            report_mismatch("refused", 32'(m_axis_tuser[1]), 32'(want.refused));
          if (m_axis_tdata[36:32] !== want.count)
            report_mismatch("entry_count", 32'(m_axis_tdata[36:32]), 32'(want.count));
          if (m_axis_tdata[37] !== want.empty)
            report_mismatch("is_empty", 32'(m_axis_tdata[37]), 32'(want.empty));
          if (m_axis_tdata[38] !== want.full)
            report_mismatch("is_full", 32'(m_axis_tdata[38]), 32'(want.full));
        end
        checked++;
      end
      m_axis_tready <= no_idle_window(checked) || $urandom_range(99) >= 8;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("sorted_priority_queue verification failed");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] rnd_value;
    logic [PRIO_W-1:0] rnd_prio;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset capacity: empty pop, extremes, equal priorities, drain past empty
    add_op(KIND_POP, 32'h1234_5678, 8'h5a);
    add_op(KIND_PUSH, 32'h8000_0000, 8'd0);
    add_op(KIND_PUSH, 32'h7fff_ffff, 8'd255);
    add_op(KIND_PUSH, 32'hffff_ffff, 8'd255);
    add_op(KIND_PUSH, 32'h0000_0000, 8'd128);
    add_op(KIND_PUSH, 32'h0000_0001, 8'd128);
    repeat (6) add_op(KIND_POP, 32'hffff_ffff, 8'hff);
    wait_idle();

    // small capacity: push onto full queue
    write_capacity(5'd2);
    add_op(KIND_PUSH, 32'h0000_0011, 8'd3);
    add_op(KIND_PUSH, 32'h0000_0022, 8'd7);
    add_op(KIND_PUSH, 32'h0000_0033, 8'd9);
    add_op(KIND_POP, 32'h0, 8'h0);
    add_op(KIND_POP, 32'h0, 8'h0);
    wait_idle();

    // zero capacity behaves as one
    write_capacity(5'd0);
    add_op(KIND_PUSH, 32'hdead_beef, 8'd1);
    add_op(KIND_PUSH, 32'hcafe_f00d, 8'd200);
    add_op(KIND_POP, 32'h0, 8'h0);
    add_op(KIND_POP, 32'h0, 8'h0);
    wait_idle();

    // phase 7 fills the queue, phase 8 lowers capacity below the count
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p][CAP_W-1:0]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rnd_value = $urandom();
        if ($urandom_range(9) == 0) rnd_value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        rnd_prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        add_op(($urandom_range(99) < phase_push_pct[p]) ? KIND_PUSH : KIND_POP,
               rnd_value, rnd_prio);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("sorted_priority_queue verification clean");
    end else begin
      $display("sorted_priority_queue verification failed");
    end
    $finish;
  end

endmodule
